[src/bpa_pkg.sv]
package bpa_pkg;

  // Pool geometry
  localparam int PAGES      = 1024;
  localparam int PG_W       = 10;
  localparam int MAX_ORDER  = 8;
  localparam int NLISTS     = MAX_ORDER + 1;
  localparam int LVL_W      = 4;
  localparam int OM_W       = 5;
  localparam int PAGE_BITS  = 12;
  localparam int ADDR_W     = 64;
  localparam int BYTES_W    = 32;
  localparam int TOP_PAGES  = 1 << MAX_ORDER;
  localparam int TOP_BLOCKS = PAGES / TOP_PAGES;
  localparam logic [PG_W-1:0] LAST_HEAD = PG_W'((TOP_BLOCKS - 1) * TOP_PAGES);
  localparam logic [OM_W-1:0] ORDER_NONE = 5'd31;

  // Result status codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_OK           = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_SIZE     = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_BLOCK     = 3'd2;
  localparam logic [ST_W-1:0] ST_NULL_ADDR    = 3'd3;
  localparam logic [ST_W-1:0] ST_OUTSIDE      = 3'd4;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 3'd5;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
  localparam logic [OP_W-1:0] OP_INIT  = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd2;
  localparam logic [OP_W-1:0] OP_AFIND = 4'd3;
  localparam logic [OP_W-1:0] OP_ATAKE = 4'd4;
  localparam logic [OP_W-1:0] OP_PUSHA = 4'd5;
  localparam logic [OP_W-1:0] OP_PUSHB = 4'd6;
  localparam logic [OP_W-1:0] OP_FCHK  = 4'd7;
  localparam logic [OP_W-1:0] OP_FCLR  = 4'd8;
  localparam logic [OP_W-1:0] OP_FRD   = 4'd9;
  localparam logic [OP_W-1:0] OP_FTEST = 4'd10;
  localparam logic [OP_W-1:0] OP_FMRG  = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT  = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } bpa_cmd_t;

  typedef struct packed {
    logic err;
    logic need_split;
    logic more;
    logic at_top;
    logic merge_ok;
    logic init_last;
  } bpa_stat_t;

endpackage

[src/bpa_ctrl.sv]
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      req_type_i,
  input  bpa_stat_t stat_i,
  output bpa_cmd_t  cmd_o,
  output logic      busy_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_AFIND = 4'd2;
  localparam logic [3:0] S_ATAKE = 4'd3;
  localparam logic [3:0] S_PUSHA = 4'd4;
  localparam logic [3:0] S_PUSHB = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FCLR  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FTEST = 4'd9;
  localparam logic [3:0] S_FMRG  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0] state_q, state_d;

  // Next state and datapath operation
  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NOP;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d = req_type_i ? S_FCHK : S_AFIND;
        end
      end
      S_AFIND: begin
        cmd_o.op = OP_AFIND;
        state_d = stat_i.err ? S_IDLE : S_ATAKE;
      end
      S_ATAKE: begin
        cmd_o.op = OP_ATAKE;
        state_d = stat_i.need_split ? S_PUSHA : S_EMIT;
      end
      S_PUSHA: begin
        cmd_o.op = OP_PUSHA;
        state_d = S_PUSHB;
      end
      S_PUSHB: begin
        cmd_o.op = OP_PUSHB;
        state_d = stat_i.more ? S_PUSHA : S_EMIT;
      end
      S_FCHK: begin
        cmd_o.op = OP_FCHK;
        state_d = stat_i.err ? S_IDLE : S_FCLR;
      end
      S_FCLR: begin
        cmd_o.op = OP_FCLR;
        state_d = stat_i.err ? S_IDLE : S_FRD;
      end
      S_FRD: begin
        cmd_o.op = OP_FRD;
        state_d = stat_i.at_top ? S_PUSHA : S_FTEST;
      end
      S_FTEST: begin
        cmd_o.op = OP_FTEST;
        state_d = stat_i.merge_ok ? S_FMRG : S_PUSHA;
      end
      S_FMRG: begin
        cmd_o.op = OP_FMRG;
        state_d = S_FRD;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[src/bpa_dp.sv]
module bpa_dp import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpa_cmd_t           cmd_i,
  output bpa_stat_t          stat_o,
  input  logic               cfg_valid_i,
  input  logic [ADDR_W-1:0]  base_address_i,
  input  logic               req_type_i,
  input  logic [BYTES_W-1:0] request_bytes_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  output logic               valid_o,
  output logic [ADDR_W-1:0]  granted_address_o,
  output logic [ST_W-1:0]    status_o,
  output logic [LVL_W-1:0]   block_order_o
);

  // Per-page memories
  logic [OM_W-1:0] ord_mem [PAGES];
  logic            use_mem [PAGES];
  logic [PG_W-1:0] nxt_mem [PAGES];
  logic [PG_W-1:0] prv_mem [PAGES];

  logic [OM_W-1:0] ord_rd_q;
  logic            use_rd_q;
  logic [PG_W-1:0] nxt_rd_q, prv_rd_q;
  logic [PG_W-1:0] raddr;

  logic            ord_we, use_we, nxt_we, prv_we;
  logic [PG_W-1:0] ord_wa, use_wa, nxt_wa, prv_wa;
  logic [OM_W-1:0] ord_wd;
  logic            use_wd;
  logic [PG_W-1:0] nxt_wd, prv_wd;

  // Free-list registers
  logic [PG_W-1:0] head_q [NLISTS];
  logic [PG_W-1:0] head_d [NLISTS];
  logic [PG_W-1:0] tail_q [NLISTS];
  logic [PG_W-1:0] tail_d [NLISTS];
  logic [NLISTS-1:0] ne_q, ne_d;

  // Working registers
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              type_q, type_d;
  logic              bad_q, bad_d;
  logic [LVL_W-1:0]  ord_q, ord_d;
  logic [LVL_W-1:0]  top_q, top_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [PG_W-1:0]   cur_q, cur_d;
  logic [PG_W-1:0]   cnt_q, cnt_d;
  logic              pb_ne_q, pb_ne_d;
  logic [PG_W-1:0]   pb_t_q, pb_t_d, pb_p_q, pb_p_d;

  logic              ov_q, ov_d;
  logic [ADDR_W-1:0] og_q, og_d;
  logic [ST_W-1:0]   os_q, os_d;
  logic [LVL_W-1:0]  oo_q, oo_d;

  // Helpers
  logic [LVL_W-1:0]  found, lsel;
  logic              fnd;
  logic [PG_W-1:0]   bud, sp, pp, pg_u;
  logic [PG_W-1:0]   head_sel, tail_sel;
  logic              ne_sel;
  logic              do_unl;
  logic [19:0]       pg_m1;
  logic [4:0]        bitlen;
  logic [ADDR_W-1:0] off;
  logic              merge_ok;
  logic [ST_W-1:0]   err_code;
  logic              err;

  // Lowest non-empty list at or above the wanted order
  always_comb begin
    found = '0;
    fnd = 1'b0;
    for (int l = MAX_ORDER; l >= 0; l--) begin
      if (ne_q[l] && (LVL_W'(l) >= ord_q)) begin
        found = LVL_W'(l);
        fnd = 1'b1;
      end
    end
  end

  // Order of a byte count: bit length of (bytes - 1) / page size
  always_comb begin
    pg_m1 = 20'((request_bytes_i - 32'd1) >> PAGE_BITS);
    bitlen = '0;
    for (int b = 0; b < 20; b++) begin
      if (pg_m1[b]) bitlen = 5'(b + 1);
    end
  end

  assign bud  = cur_q ^ (PG_W'(1) << lvl_q);
  assign sp   = cur_q + (PG_W'(1) << lvl_q);
  assign pp   = type_q ? cur_q : sp;
  assign off  = addr_q - base_q;
  assign pg_u = (cmd_i.op == OP_ATAKE) ? cur_q : bud;

  // One list entry is looked at per cycle
  always_comb begin
    unique case (cmd_i.op)
      OP_AFIND: lsel = found;
      OP_ATAKE: lsel = top_q;
      default:  lsel = lvl_q;
    endcase
  end
  assign head_sel = head_q[lsel];
  assign tail_sel = tail_q[lsel];
  assign ne_sel   = ne_q[lsel];

  assign merge_ok = (ord_rd_q == {1'b0, lvl_q}) && !use_rd_q;

  // Error detection for the check operations
  always_comb begin
    err = 1'b0;
    err_code = ST_OK;
    unique case (cmd_i.op)
      OP_AFIND: begin
        err = bad_q || !fnd;
        err_code = bad_q ? ST_BAD_SIZE : ST_NO_BLOCK;
      end
      OP_FCHK: begin
        err = (addr_q == '0) || (off[ADDR_W-1:PAGE_BITS+PG_W] != '0);
        err_code = (addr_q == '0) ? ST_NULL_ADDR : ST_OUTSIDE;
      end
      OP_FCLR: begin
        err = !use_rd_q;
        err_code = ST_ALREADY_FREE;
      end
      default: begin
        err = 1'b0;
        err_code = ST_OK;
      end
    endcase
  end

  assign stat_o.err        = err;
  assign stat_o.need_split = (ord_q < top_q);
  assign stat_o.more       = !type_q && ((5'(lvl_q) + 5'd1) < 5'(top_q));
  assign stat_o.at_top     = (lvl_q == LVL_W'(MAX_ORDER));
  assign stat_o.merge_ok   = merge_ok;
  assign stat_o.init_last  = (cnt_q == PG_W'(PAGES - 1));

  // Operation decode
  always_comb begin
    base_d = cfg_valid_i ? base_address_i : base_q;
    addr_d = addr_q;
    type_d = type_q;
    bad_d = bad_q;
    ord_d = ord_q;
    top_d = top_q;
    lvl_d = lvl_q;
    cur_d = cur_q;
    cnt_d = cnt_q;
    pb_ne_d = pb_ne_q;
    pb_t_d = pb_t_q;
    pb_p_d = pb_p_q;
    head_d = head_q;
    tail_d = tail_q;
    ne_d = ne_q;
    ov_d = 1'b0;
    og_d = og_q;
    os_d = os_q;
    oo_d = oo_q;
    raddr = cur_q;
    do_unl = 1'b0;
    ord_we = 1'b0; ord_wa = cur_q; ord_wd = '0;
    use_we = 1'b0; use_wa = cur_q; use_wd = 1'b0;
    nxt_we = 1'b0; nxt_wa = cur_q; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = cur_q; prv_wd = '0;

    // Report a failed check
    if (err) begin
      ov_d = 1'b1;
      og_d = '0;
      os_d = err_code;
      oo_d = '0;
    end

    unique case (cmd_i.op)
      OP_NOP: ;
      OP_INIT: begin
        // Clearing pass: top-order heads chained in ascending order
        ord_we = 1'b1; ord_wa = cnt_q;
        use_we = 1'b1; use_wa = cnt_q; use_wd = 1'b0;
        nxt_we = 1'b1; nxt_wa = cnt_q;
        prv_we = 1'b1; prv_wa = cnt_q;
        if ((cnt_q % TOP_PAGES) == 0) begin
          ord_wd = OM_W'(MAX_ORDER);
          nxt_wd = (cnt_q == LAST_HEAD) ? cnt_q : cnt_q + PG_W'(TOP_PAGES);
          prv_wd = (cnt_q == '0) ? cnt_q : cnt_q - PG_W'(TOP_PAGES);
        end else begin
          ord_wd = ORDER_NONE;
        end
        cnt_d = cnt_q + PG_W'(1);
      end
      OP_LOAD: begin
        type_d = req_type_i;
        addr_d = block_address_i;
        bad_d = (request_bytes_i == '0) || (bitlen > 5'(MAX_ORDER));
        ord_d = bitlen[LVL_W-1:0];
      end
      OP_AFIND: begin
        top_d = found;
        cur_d = head_sel;
        raddr = head_sel;
      end
      OP_ATAKE: begin
        do_unl = 1'b1;
        ord_we = 1'b1; ord_wa = cur_q; ord_wd = OM_W'(ord_q);
        use_we = 1'b1; use_wa = cur_q; use_wd = 1'b1;
        lvl_d = ord_q;
      end
      OP_PUSHA: begin
        // Append page to the tail of its list
        nxt_we = 1'b1; nxt_wa = pp; nxt_wd = pp;
        prv_we = 1'b1; prv_wa = pp; prv_wd = ne_sel ? tail_sel : pp;
        if (!type_q) begin
          ord_we = 1'b1; ord_wa = pp; ord_wd = OM_W'(lvl_q);
          use_we = 1'b1; use_wa = pp; use_wd = 1'b0;
        end
        if (!ne_sel) begin
          head_d[lsel] = pp;
          ne_d[lsel] = 1'b1;
        end
        tail_d[lsel] = pp;
        pb_ne_d = ne_sel;
        pb_t_d = tail_sel;
        pb_p_d = pp;
      end
      OP_PUSHB: begin
        if (pb_ne_q) begin
          nxt_we = 1'b1; nxt_wa = pb_t_q; nxt_wd = pb_p_q;
        end
        if (!type_q) lvl_d = lvl_q + LVL_W'(1);
      end
      OP_FCHK: begin
        cur_d = off[PAGE_BITS +: PG_W];
        raddr = off[PAGE_BITS +: PG_W];
      end
      OP_FCLR: begin
        if (use_rd_q) begin
          use_we = 1'b1; use_wa = cur_q; use_wd = 1'b0;
          lvl_d = (ord_rd_q > OM_W'(MAX_ORDER)) ? LVL_W'(MAX_ORDER) : ord_rd_q[LVL_W-1:0];
        end
      end
      OP_FRD: begin
        raddr = bud;
      end
      OP_FTEST: begin
        if (merge_ok) begin
          do_unl = 1'b1;
          ord_we = 1'b1;
          ord_wa = (cur_q > bud) ? cur_q : bud;
          ord_wd = ORDER_NONE;
          cur_d = (cur_q > bud) ? bud : cur_q;
        end
      end
      OP_FMRG: begin
        ord_we = 1'b1; ord_wa = cur_q; ord_wd = OM_W'(lvl_q) + OM_W'(1);
        lvl_d = lvl_q + LVL_W'(1);
      end
      OP_EMIT: begin
        ov_d = 1'b1;
        os_d = ST_OK;
        og_d = type_q ? '0 : base_q + {{(ADDR_W-PG_W-PAGE_BITS){1'b0}}, cur_q,
                                       {PAGE_BITS{1'b0}}};
        oo_d = type_q ? lvl_q : ord_q;
      end
      default: ;
    endcase

    // Remove a page from the list it sits on
    if (do_unl && ne_sel) begin
      if ((head_sel == pg_u) && (tail_sel == pg_u)) begin
        ne_d[lsel] = 1'b0;
        head_d[lsel] = '0;
        tail_d[lsel] = '0;
      end else if (head_sel == pg_u) begin
        head_d[lsel] = nxt_rd_q;
      end else if (tail_sel == pg_u) begin
        tail_d[lsel] = prv_rd_q;
      end else begin
        nxt_we = 1'b1; nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
        prv_we = 1'b1; prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
      end
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd_q <= ord_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (use_we) use_mem[use_wa] <= use_wd;
    use_rd_q <= use_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_q <= nxt_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd_q <= prv_mem[raddr];
  end

  // Control state and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cnt_q <= '0;
      ov_q <= 1'b0;
      ne_q <= NLISTS'(1) << MAX_ORDER;
      for (int l = 0; l < NLISTS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= (l == MAX_ORDER) ? LAST_HEAD : '0;
      end
    end else begin
      base_q <= base_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
      ne_q <= ne_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    type_q <= type_d;
    bad_q <= bad_d;
    ord_q <= ord_d;
    top_q <= top_d;
    lvl_q <= lvl_d;
    cur_q <= cur_d;
    pb_ne_q <= pb_ne_d;
    pb_t_q <= pb_t_d;
    pb_p_q <= pb_p_d;
    og_q <= og_d;
    os_q <= os_d;
    oo_q <= oo_d;
  end

  assign valid_o = ov_q;
  assign granted_address_o = og_q;
  assign status_o = os_q;
  assign block_order_o = oo_q;

endmodule

[src/buddy_page_allocator.sv]
// Channel   Handshake              Payload
// request   start_i / busy_o       req_type_i, request_bytes_i, block_address_i
// result    valid_o (strobe)       granted_address_o, status_o, block_order_o
// config    cfg_valid_i / cfg_ready_o   base_address_i
//
// An allocate takes a head block and splits it down to the wanted order; a
// free checks the address, clears the used flag and merges with free buddies;
// each step waits on the registered reads of the page link memories. A check
// that fails ends the request. After reset a clearing pass over all 1024 pages
// initializes the page memories, with busy_o high. A result is shown for one
// cycle on the valid_o strobe; the next request can be taken in that cycle.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [BYTES_W-1:0] request_bytes_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ADDR_W-1:0]  base_address_i,
  output logic               valid_o,
  output logic [ADDR_W-1:0]  granted_address_o,
  output logic [ST_W-1:0]    status_o,
  output logic [LVL_W-1:0]   block_order_o
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  // The base register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  bpa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .base_address_i    (base_address_i),
    .req_type_i        (req_type_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .valid_o           (valid_o),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .block_order_o     (block_order_o)
  );

`ifndef SYNTH
  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  // A failed request reports no address and no order.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (granted_address_o == '0 && block_order_o == '0))
    else $error("error result carries payload");

  // Orders reported never exceed the top order.
  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (block_order_o <= LVL_W'(MAX_ORDER)))
    else $error("block order out of range");

  // A result strobe is a single cycle while the block works on a request.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && busy_o) |=> !valid_o)
    else $error("result strobe repeated");
`endif

endmodule

[dv/buddy_page_allocator_tb.sv]
`timescale 1ns / 1ps

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_RANDOM = 2000;

  // One expected response of the allocator.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]   status;
    logic [LVL_W-1:0]  order;
  } alloc_resp_t;

  // Shadow of the free lists and page tables, plus the queue of pending responses.
  class alloc_scoreboard;
    logic [ADDR_W-1:0] base;
    logic [OM_W-1:0]   pg_order [PAGES];
    bit                pg_used  [PAGES];
    int unsigned       nxt [PAGES];
    int unsigned       prv [PAGES];
    int unsigned       head [NLISTS];
    int unsigned       tail [NLISTS];
    bit                filled [NLISTS];
    alloc_resp_t       pending [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       status_seen [8];

    function new();
      base = '0;
      errors = 0;
      checked = 0;
      for (int k = 0; k < 8; k++) status_seen[k] = 0;
      for (int k = 0; k < PAGES; k++) begin
        pg_order[k] = ORDER_NONE;
        pg_used[k] = 0;
        nxt[k] = 0;
        prv[k] = 0;
      end
      for (int k = 0; k < NLISTS; k++) begin
        head[k] = 0;
        tail[k] = 0;
        filled[k] = 0;
      end
      for (int k = 0; k < TOP_BLOCKS; k++) begin
        pg_order[k * TOP_PAGES] = OM_W'(MAX_ORDER);
        append(MAX_ORDER, k * TOP_PAGES);
      end
    endfunction

    function void append(int unsigned lvl, int unsigned pg);
      if (filled[lvl]) begin
        nxt[tail[lvl]] = pg;
        prv[pg] = tail[lvl];
      end else begin
        head[lvl] = pg;
        prv[pg] = pg;
        filled[lvl] = 1;
      end
      nxt[pg] = pg;
      tail[lvl] = pg;
    endfunction

    function void detach(int unsigned lvl, int unsigned pg);
      bit is_h;
      bit is_t;
      if (!filled[lvl]) return;
      is_h = (head[lvl] == pg);
      is_t = (tail[lvl] == pg);
      if (is_h && is_t) begin
        filled[lvl] = 0;
        head[lvl] = 0;
        tail[lvl] = 0;
      end else if (is_h) begin
        head[lvl] = nxt[pg];
      end else if (is_t) begin
        tail[lvl] = prv[pg];
      end else begin
        nxt[prv[pg]] = nxt[pg];
        prv[nxt[pg]] = prv[pg];
      end
    endfunction

    // Work out the response of one accepted request and update the shadow state.
    function void note_request(bit is_free, logic [BYTES_W-1:0] bytes,
                               logic [ADDR_W-1:0] addr);
      alloc_resp_t r;
      logic [63:0] npg;
      logic [63:0] idx;
      int unsigned ord;
      int unsigned lvl;
      int unsigned pg;
      int unsigned cur;
      int unsigned bud;
      r.addr = '0;
      r.status = ST_OK;
      r.order = '0;
      if (!is_free) begin
        ord = 0;
        npg = (64'(bytes) + 64'd4095) >> PAGE_BITS;
        while (ord < 40 && (64'd1 << ord) < npg) ord++;
        if (bytes == 0 || ord > MAX_ORDER) begin
          r.status = ST_BAD_SIZE;
        end else begin
          lvl = ord;
          while (lvl <= MAX_ORDER && !filled[lvl]) lvl++;
          if (lvl > MAX_ORDER) begin
            r.status = ST_NO_BLOCK;
          end else begin
            pg = head[lvl];
            detach(lvl, pg);
            pg_used[pg] = 1;
            pg_order[pg] = OM_W'(ord);
            // Upper halves split off on the way down go to the lower lists.
            for (int unsigned j = ord; j < lvl; j++) begin
              if (pg + (1 << j) < PAGES) begin
                pg_used[pg + (1 << j)] = 0;
                pg_order[pg + (1 << j)] = OM_W'(j);
                append(j, pg + (1 << j));
              end
            end
            r.addr = base + (64'(pg) << PAGE_BITS);
            r.order = LVL_W'(ord);
          end
        end
      end else if (addr == 0) begin
        r.status = ST_NULL_ADDR;
      end else begin
        idx = (addr - base) >> PAGE_BITS;
        if (idx >= PAGES) begin
          r.status = ST_OUTSIDE;
        end else if (!pg_used[idx]) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          cur = idx;
          pg_used[cur] = 0;
          lvl = pg_order[cur];
          if (lvl > MAX_ORDER) lvl = MAX_ORDER;
          // Merge with free buddies of equal order as far up as possible.
          while (lvl < MAX_ORDER) begin
            bud = cur ^ (1 << lvl);
            if (bud < PAGES && pg_order[bud] == lvl && !pg_used[bud]) begin
              detach(lvl, bud);
              if (cur > bud) begin
                pg_order[cur] = ORDER_NONE;
                cur = bud;
              end else begin
                pg_order[bud] = ORDER_NONE;
              end
              pg_order[cur] = OM_W'(lvl + 1);
              lvl++;
            end else begin
              break;
            end
          end
          append(lvl, cur);
          r.order = LVL_W'(lvl);
        end
      end
      status_seen[r.status]++;
      pending.push_back(r);
    endfunction

    function void report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      errors++;
      $display("ERROR result %0d: %s got 0x%0h expected 0x%0h", checked, what, got, want);
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [ST_W-1:0] st,
                               logic [LVL_W-1:0] ord);
      alloc_resp_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("ERROR result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (addr !== e.addr) report("granted_address", addr, e.addr);
      if (st !== e.status) report("status", 64'(st), 64'(e.status));
      if (ord !== e.order) report("block_order", 64'(ord), 64'(e.order));
      checked++;
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              start_i = 0;
  logic              busy_o;
  logic              req_type_i = 0;
  logic [BYTES_W-1:0] request_bytes_i = '0;
  logic [ADDR_W-1:0] block_address_i = '0;
  logic              cfg_valid_i = 0;
  logic              cfg_ready_o;
  logic [ADDR_W-1:0] base_address_i = '0;
  logic              valid_o;
  logic [ADDR_W-1:0] granted_address_o;
  logic [ST_W-1:0]   status_o;
  logic [LVL_W-1:0]  block_order_o;

  alloc_scoreboard sb;
  int unsigned cycles = 0;
  bit no_gaps = 0;
  logic [ADDR_W-1:0] granted [$];

  always #4 clk_i = ~clk_i;

  buddy_page_allocator u_top (.*);

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (status_o == ST_OK && sb.pending.size() > 0 && sb.pending[0].addr != 0)
        granted.push_back(granted_address_o);
      sb.check_result(granted_address_o, status_o, block_order_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("buddy_page_allocator: mismatch");
      $finish;
    end
  end

  // Start stays high from one item to the next unless an idle stretch comes between.
  task automatic send(bit is_free, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
    bit idle;
    idle = !no_gaps && ($urandom_range(99) < 36);
    if (idle) start_i <= 0;
    while (idle) begin
      @(posedge clk_i);
      idle = !no_gaps && ($urandom_range(99) < 36);
    end
    start_i <= 1;
    req_type_i <= is_free;
    request_bytes_i <= bytes;
    block_address_i <= addr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(is_free, bytes, addr);
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_base(logic [ADDR_W-1:0] value);
    drain();
    cfg_valid_i <= 1;
    base_address_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    sb.base = value;
    granted.delete();
  endtask

  // Free a previously granted block, or pick at random when none is held.
  task automatic free_some();
    int unsigned k;
    logic [ADDR_W-1:0] a;
    if (granted.size() == 0) begin
      send(1, $urandom, sb.base + (64'($urandom_range(PAGES - 1)) << PAGE_BITS));
      return;
    end
    k = $urandom_range(granted.size() - 1);
    a = granted[k];
    granted.delete(k);
    send(1, $urandom, a + 64'($urandom_range(4095)));
  endtask

  task automatic random_phase(int unsigned n, logic [ADDR_W-1:0] base_val);
    int unsigned sel;
    logic [BYTES_W-1:0] sz;
    set_base(base_val);
    for (int unsigned i = 0; i < n; i++) begin
      no_gaps = (i >= n / 3 && i < n / 3 + 60);
      sel = $urandom_range(99);
      if (sel < 45) begin
        sz = (sel < 35) ? BYTES_W'($urandom_range(1, 1 << ($urandom_range(20))))
                        : BYTES_W'($urandom);
        send(0, sz, {$urandom, $urandom});
      end else if (sel < 88) begin
        free_some();
      end else if (sel < 92) begin
        send(1, $urandom, '0);
      end else begin
        send(1, $urandom, {$urandom, $urandom});
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: size extremes, exhaustion, bad addresses, merges.
    send(0, '0, '0);
    send(0, 32'd1, '1);
    send(0, 32'd4096, '0);
    send(0, 32'd4097, '0);
    send(0, 32'h0010_0000, '0);
    send(0, 32'h0010_0001, '0);
    send(0, '1, '0);
    send(1, '1, '0);
    send(1, '0, 64'h0000_0000_0040_0000);
    send(1, '0, '1);
    send(1, '0, 64'h0000_0000_0000_5123);
    send(1, '0, 64'h0000_0000_0000_1fff);
    send(1, '0, 64'h0000_0000_0000_1000);
    for (int k = 0; k < 5; k++) send(0, 32'h0010_0000, '0);
    for (int k = 0; k < 4; k++) free_some();
    send(1, '0, 64'h0000_0000_0000_1000);
    drain();

    random_phase(700, '0);
    random_phase(500, 64'hFFFF_FFFF_FFFF_F000);
    random_phase(500, {$urandom, $urandom});
    random_phase(300, 64'h0000_0000_8000_0000);
    drain();

    $display("covered %0d results: ok %0d, bad size %0d, exhausted %0d", sb.checked,
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_SIZE], sb.status_seen[ST_NO_BLOCK]);
    $display("null %0d, outside %0d, already free %0d, four base settings",
             sb.status_seen[ST_NULL_ADDR], sb.status_seen[ST_OUTSIDE],
             sb.status_seen[ST_ALREADY_FREE]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("buddy_page_allocator: match");
    end else begin
      $display("buddy_page_allocator: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
src/bpa_pkg.sv
src/bpa_ctrl.sv
src/bpa_dp.sv
src/buddy_page_allocator.sv
dv/buddy_page_allocator_tb.sv
